FILE: sv/tsr_pkg.sv
// tsr_pkg: shared types and constants of the tlv timestamp rewriter
// used by tlv_timestamp_rewriter; no dependencies
`default_nettype none

package tsr_pkg;

   localparam int TIME_BYTES  = 4;
   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 8;

   localparam logic MODE_UNPACK = 1'b0;
   localparam logic MODE_PACK   = 1'b1;

   localparam logic [1:0] CSR_CONVERT_MODE = 2'd0;
   localparam logic [1:0] CSR_TIME_TYPE    = 2'd1;
   localparam logic [1:0] CSR_SUBLIST_TYPE = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] now_seconds;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       malformed;
   } rsp_type;

   function automatic logic [31:0] byte_swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

FILE: sv/tlv_timestamp_rewriter.sv
// tlv_timestamp_rewriter: parses a tlv byte stream and rewrites time values
// depends on tsr_pkg for payload structs, register indexes and constants
// a byte's results are queued at acceptance and shown at rsp in order behind earlier results
// throughput: one byte per cycle; a time value's four bytes leave an 8-entry queue one per cycle,
// both while not stalled; req_stall is high while more than four results are queued
// reset (synchronous) clears registers, parser state and the result queue
`default_nettype none

module tlv_timestamp_rewriter #(
   parameter int HEADER_BYTES = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tsr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tsr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_wdata
);
   import tsr_pkg::*;

   localparam int PW  = $clog2(HEADER_BYTES + 1);
   localparam int QPW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic        mode_ff;
   logic [7:0]  ttc_ff;
   logic [7:0]  stc_ff;

   logic [PW-1:0] hpos_ff, hpos_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    vrem_ff, vrem_in;
   logic [2:0]    tbc_ff, tbc_in;
   logic [31:0]   buf_ff, buf_in;
   logic [31:0]   latched_ff, latched_in;
   logic          in_packet_ff, in_packet_in;

   rsp_type            queue_ff [QUEUE_DEPTH];
   logic [QPW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]     count_ff;

   logic          req_accept, rsp_accept;
   logic [31:0]   now_eff;
   logic [31:0]   buf_shift;
   logic [31:0]   sum;
   logic [31:0]   diff;
   logic [31:0]   r;
   logic [2:0]    tbc_inc;
   logic          timed_cur;
   logic          capture;
   logic          hdr_bad;
   logic          last;
   logic [7:0]    byte_in;
   rsp_type       res [MAX_RESULTS];
   logic [2:0]    nres;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > QCW'(QUEUE_DEPTH - MAX_RESULTS);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = queue_ff[rd_ptr_ff];

   assign last      = req_data.last_byte;
   assign byte_in   = req_data.data_byte;
   assign now_eff   = in_packet_ff ? latched_ff : req_data.now_seconds;
   assign buf_shift = {buf_ff[23:0], byte_in};
   assign tbc_inc   = tbc_ff + 3'd1;
   assign sum       = now_eff + buf_shift;
   assign diff      = byte_swap32(buf_shift) - now_eff;
   assign r         = (mode_ff == MODE_UNPACK) ? sum : byte_swap32(diff);
   assign timed_cur = (type_ff == ttc_ff) && (type_ff != stc_ff);
   assign capture   = timed_cur && (tbc_ff < 3'(TIME_BYTES)) &&
                      ((9'(tbc_ff) + 9'(vrem_ff)) >= 9'(TIME_BYTES));

   always_comb begin
      hpos_in      = hpos_ff;
      type_in      = type_ff;
      vrem_in      = vrem_ff;
      tbc_in       = tbc_ff;
      buf_in       = buf_ff;
      latched_in   = now_eff;
      in_packet_in = !last;
      hdr_bad      = 1'b0;
      nres         = 3'd0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res[k] = '{8'h00, 1'b0, 1'b0};
      end
      if (hpos_ff == PW'(HEADER_BYTES)) begin
         vrem_in = vrem_ff - 8'd1;
         if (capture) begin
            buf_in = buf_shift;
            tbc_in = tbc_inc;
            if (tbc_inc == 3'(TIME_BYTES)) begin
               // r goes out low byte first: little-endian in unpack mode; pack mode byte-swaps the difference into r
               res[0] = '{r[7:0],   1'b0, 1'b0};
               res[1] = '{r[15:8],  1'b0, 1'b0};
               res[2] = '{r[23:16], 1'b0, 1'b0};
               res[3] = '{r[31:24], last, 1'b0};
               nres   = 3'd4;
            end else if (last) begin
               nres = tbc_inc;
               case (tbc_inc)
                  3'd1: begin
                     res[0] = '{buf_shift[7:0], 1'b1, 1'b1};
                  end
                  3'd2: begin
                     res[0] = '{buf_shift[15:8], 1'b0, 1'b1};
                     res[1] = '{buf_shift[7:0],  1'b1, 1'b1};
                  end
                  3'd3: begin
                     res[0] = '{buf_shift[23:16], 1'b0, 1'b1};
                     res[1] = '{buf_shift[15:8],  1'b0, 1'b1};
                     res[2] = '{buf_shift[7:0],   1'b1, 1'b1};
                  end
                  default: begin
                     nres = 3'd0;
                  end
               endcase
            end
         end else begin
            res[0] = '{byte_in, last, timed_cur && (tbc_ff < 3'(TIME_BYTES))};
            nres   = 3'd1;
         end
         if (vrem_in == 8'd0) begin
            hpos_in = '0;
         end
      end else begin
         if (hpos_ff == PW'(1)) begin
            type_in = byte_in;
         end
         if (hpos_ff == PW'(2)) begin
            vrem_in = byte_in;
         end
         if (hpos_ff == PW'(HEADER_BYTES - 1)) begin
            tbc_in = 3'd0;
            buf_in = 32'd0;
            if (type_in == stc_ff) begin
               vrem_in = 8'd0;
            end
            hdr_bad = (type_in == ttc_ff) && (type_in != stc_ff) &&
                      (vrem_in < 8'(TIME_BYTES));
            hpos_in = (vrem_in != 8'd0) ? PW'(HEADER_BYTES) : '0;
         end else begin
            hpos_in = hpos_ff + PW'(1);
         end
         res[0] = '{byte_in, last, hdr_bad};
         nres   = 3'd1;
      end
      if (last) begin
         hpos_in = '0;
         type_in = 8'd0;
         vrem_in = 8'd0;
         tbc_in  = 3'd0;
         buf_in  = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNPACK;
         ttc_ff       <= 8'd0;
         stc_ff       <= 8'd0;
         hpos_ff      <= '0;
         type_ff      <= 8'd0;
         vrem_ff      <= 8'd0;
         tbc_ff       <= 3'd0;
         buf_ff       <= 32'd0;
         latched_ff   <= 32'd0;
         in_packet_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CONVERT_MODE: mode_ff <= csr_wdata[0];
               CSR_TIME_TYPE:    ttc_ff  <= csr_wdata;
               CSR_SUBLIST_TYPE: stc_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            hpos_ff      <= hpos_in;
            type_ff      <= type_in;
            vrem_ff      <= vrem_in;
            tbc_ff       <= tbc_in;
            buf_ff       <= buf_in;
            latched_ff   <= latched_in;
            in_packet_ff <= in_packet_in;
            wr_ptr_ff    <= wr_ptr_ff + QPW'(nres);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         count_ff <= count_ff + (req_accept ? QCW'(nres) : '0) - QCW'(rsp_accept);
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (req_accept && (3'(k) < nres)) begin
            queue_ff[wr_ptr_ff + QPW'(k)] <= res[k];
         end
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_idle_header: assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> (hpos_ff == '0) && (tbc_ff == 3'd0))
      else $error("parser state left over between packets");

   a_time_count: assert property (@(posedge clock) disable iff (reset)
      tbc_ff <= 3'(TIME_BYTES))
      else $error("time byte count out of range");

   a_packet_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.last_byte |=> !in_packet_ff && (hpos_ff == '0))
      else $error("packet end did not return parser to header start");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for tlv_timestamp_rewriter: directed table, then random tlv packets
// checked against an in-bench predictor; depends on tsr_pkg and the rewriter rtl
`timescale 1ns / 1ps

module testbench;
   import tsr_pkg::*;

   localparam int HDR_BYTES      = 3;
   localparam int HOLD_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [7:0] DIR_TIME_CODE = 8'h07;
   localparam logic [7:0] DIR_SUB_CODE  = 8'h0C;

   typedef enum {KIND_TIME, KIND_SUBLIST, KIND_OTHER, KIND_SHORT, KIND_CUT} item_kind_type;

   typedef struct {
      bit         is_cfg;
      req_type    item;
      bit         known;
      bit         known_bad;
      logic       mode;
      logic [7:0] time_code;
      logic [7:0] sub_code;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_CONVERT_MODE;
   logic [7:0] csr_wdata = 8'h00;

   // predictor state and register copies
   logic       cfg_mode = MODE_UNPACK;
   logic [7:0] cfg_time_code = 8'h00;
   logic [7:0] cfg_sublist_code = 8'h00;
   logic [2:0] parse_pos = 3'd0;
   logic [7:0] cur_type = 8'h00;
   logic [7:0] value_left = 8'h00;
   logic [2:0] held_count = 3'd0;
   logic [31:0] held_time = 32'h0;
   logic [31:0] pkt_now = 32'h0;
   logic       pkt_open = 1'b0;

   rsp_type      step_out[$];
   rsp_type      expected_bytes[$];
   stim_row_type plan[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int errors = 0;
   int bytes_sent = 0;
   int bytes_out = 0;
   int rewrites = 0;
   int malformed_bytes = 0;

   tlv_timestamp_rewriter #(.HEADER_BYTES(HDR_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic is_time_item(input logic [7:0] t);
      return t == cfg_time_code && t != cfg_sublist_code;
   endfunction

   // expected output bytes of one accepted input byte, left in step_out
   task automatic rewrite_byte(input req_type d);
      logic [7:0]  rem;
      logic        timed;
      logic        bad;
      logic [31:0] r;
      logic [31:0] le;
      int          k;
      int          c;
      step_out.delete();
      if (!pkt_open) begin
         pkt_now = d.now_seconds;
         pkt_open = 1'b1;
      end
      if (parse_pos >= HDR_BYTES) begin
         rem = value_left;
         timed = is_time_item(cur_type);
         value_left = rem - 8'd1;
         if (timed && held_count < TIME_BYTES && int'(held_count) + int'(rem) >= TIME_BYTES) begin
            held_time = {held_time[23:0], d.data_byte};
            held_count = held_count + 3'd1;
            if (held_count == TIME_BYTES) begin
               rewrites++;
               if (cfg_mode == MODE_UNPACK) begin
                  r = pkt_now + held_time;
                  for (k = 0; k < TIME_BYTES; k++)
                     step_out.push_back(rsp_type'{r[8*k +: 8], d.last_byte && k == 3, 1'b0});
               end else begin
                  le = {held_time[7:0], held_time[15:8], held_time[23:16], held_time[31:24]};
                  r = le - pkt_now;
                  for (k = 0; k < TIME_BYTES; k++)
                     step_out.push_back(rsp_type'{r[8*(3-k) +: 8], d.last_byte && k == 3, 1'b0});
               end
            end else if (d.last_byte) begin
               c = held_count;
               for (k = 0; k < c; k++)
                  step_out.push_back(rsp_type'{held_time[8*(c-1-k) +: 8], k == c-1, 1'b1});
            end
         end else begin
            bad = timed && held_count < TIME_BYTES;
            step_out.push_back(rsp_type'{d.data_byte, d.last_byte, bad});
         end
         if (value_left == 8'd0) parse_pos = 3'd0;
      end else begin
         bad = 1'b0;
         if (parse_pos == 3'd1) cur_type = d.data_byte;
         if (parse_pos == 3'd2) value_left = d.data_byte;
         if (parse_pos == HDR_BYTES - 1) begin
            held_count = 3'd0;
            held_time = 32'h0;
            if (cur_type == cfg_sublist_code) value_left = 8'd0;
            if (is_time_item(cur_type) && value_left < TIME_BYTES) bad = 1'b1;
            parse_pos = (value_left != 8'd0) ? 3'(HDR_BYTES) : 3'd0;
         end else begin
            parse_pos = parse_pos + 3'd1;
         end
         step_out.push_back(rsp_type'{d.data_byte, d.last_byte, bad});
      end
      if (d.last_byte) begin
         parse_pos = 3'd0;
         cur_type = 8'h00;
         value_left = 8'h00;
         held_count = 3'd0;
         held_time = 32'h0;
         pkt_open = 1'b0;
      end
      foreach (step_out[i]) if (step_out[i].malformed) malformed_bytes++;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_byte(input req_type d, input bit known, input bit known_bad);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      rewrite_byte(d);
      if (known) expected_bytes.push_back(rsp_type'{d.data_byte, d.last_byte, known_bad});
      else foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
   endtask

   // registers change only with nothing in flight
   task automatic load_config(input logic mode, input logic [7:0] tcode, input logic [7:0] scode);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_CONVERT_MODE;
      csr_wdata <= {7'd0, mode};
      @(posedge clock);
      csr_index <= CSR_TIME_TYPE;
      csr_wdata <= tcode;
      @(posedge clock);
      csr_index <= CSR_SUBLIST_TYPE;
      csr_wdata <= scode;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mode = mode;
      cfg_time_code = tcode;
      cfg_sublist_code = scode;
   endtask

   task automatic send_packet();
      logic [7:0]    pkt[$];
      logic [7:0]    code;
      logic [31:0]   now;
      item_kind_type kind;
      int            n_items;
      int            len;
      int            pick;
      int            i;
      int            j;
      now = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(1, 8);
         for (j = 0; j < len; j++) pkt.push_back(8'($urandom));
      end else begin
         n_items = $urandom_range(1, 3);
         for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            kind = pick < 5 ? KIND_TIME : pick == 5 ? KIND_SUBLIST :
                   pick < 8 ? KIND_OTHER : pick == 8 ? KIND_SHORT : KIND_CUT;
            case (kind)
               KIND_TIME: begin
                  code = cfg_time_code;
                  len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : TIME_BYTES;
               end
               KIND_SUBLIST: begin
                  code = cfg_sublist_code;
                  len = $urandom_range(0, 255);
               end
               KIND_OTHER: begin
                  code = 8'($urandom);
                  len = $urandom_range(0, 5);
               end
               KIND_SHORT: begin
                  code = cfg_time_code;
                  len = $urandom_range(0, TIME_BYTES - 1);
               end
               default: begin
                  code = cfg_time_code;
                  len = $urandom_range(TIME_BYTES, 255);
               end
            endcase
            pkt.push_back(8'($urandom));
            pkt.push_back(code);
            pkt.push_back(8'(len));
            if (kind == KIND_SUBLIST) len = 0;
            if (kind == KIND_CUT) len = $urandom_range(1, 6);
            for (j = 0; j < len; j++) pkt.push_back(8'($urandom));
            if (kind == KIND_CUT) break;
         end
      end
      for (j = 0; j < pkt.size(); j++)
         send_byte(req_type'{pkt[j], now, j == pkt.size() - 1}, 1'b0, 1'b0);
   endtask

   task automatic random_phase(input logic mode, input logic [7:0] tcode,
                               input logic [7:0] scode, input int count);
      int goal;
      load_config(mode, tcode, scode);
      goal = bytes_sent + count;
      while (bytes_sent < goal) send_packet();
   endtask

   task automatic add_cfg(input logic mode, input logic [7:0] tcode, input logic [7:0] scode);
      stim_row_type row;
      row = '{is_cfg: 1'b1, item: '0, known: 1'b0, known_bad: 1'b0,
              mode: mode, time_code: tcode, sub_code: scode};
      plan.push_back(row);
   endtask

   task automatic add_byte(input logic [7:0] b, input logic [31:0] now, input logic last,
                           input bit known, input bit bad);
      stim_row_type row;
      row = '{is_cfg: 1'b0, item: req_type'{b, now, last}, known: known, known_bad: bad,
              mode: MODE_UNPACK, time_code: 8'h00, sub_code: 8'h00};
      plan.push_back(row);
   endtask

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_out++;
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected transaction, byte", rsp_data.out_byte, 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
            if (rsp_data.out_last !== want.out_last)
               report_mismatch("out_last", rsp_data.out_last, want.out_last);
            if (rsp_data.malformed !== want.malformed)
               report_mismatch("malformed", rsp_data.malformed, want.malformed);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // long time value with wrap, trailing byte passes through
      add_cfg(MODE_UNPACK, DIR_TIME_CODE, DIR_SUB_CODE);
      add_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1, 0);
      add_byte(DIR_TIME_CODE, 32'hFFFF_FFFF, 1'b0, 1, 0);
      add_byte(8'h05, 32'hFFFF_FFFF, 1'b0, 1, 0);
      add_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 0, 0);
      add_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 0, 0);
      add_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 0, 0);
      add_byte(8'h20, 32'hFFFF_FFFF, 1'b0, 0, 0);
      add_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1, 0);
      // sub-list header, short time value, truncated time value
      add_byte(8'h01, 32'h0, 1'b0, 1, 0);
      add_byte(DIR_SUB_CODE, 32'h0, 1'b0, 1, 0);
      add_byte(8'h09, 32'h0, 1'b0, 1, 0);
      add_byte(8'h02, 32'h0, 1'b0, 1, 0);
      add_byte(DIR_TIME_CODE, 32'h0, 1'b0, 1, 0);
      add_byte(8'h01, 32'h0, 1'b0, 1, 1);
      add_byte(8'hAA, 32'h0, 1'b0, 1, 1);
      add_byte(8'h03, 32'h0, 1'b0, 1, 0);
      add_byte(DIR_TIME_CODE, 32'h0, 1'b0, 1, 0);
      add_byte(8'h04, 32'h0, 1'b0, 1, 0);
      add_byte(8'h11, 32'h0, 1'b1, 1, 1);
      // pack mode, packet ends on the last time byte
      add_cfg(MODE_PACK, DIR_TIME_CODE, DIR_SUB_CODE);
      add_byte(8'h04, 32'h0000_0001, 1'b0, 1, 0);
      add_byte(DIR_TIME_CODE, 32'h0000_0001, 1'b0, 1, 0);
      add_byte(8'h04, 32'h0000_0001, 1'b0, 1, 0);
      add_byte(8'h10, 32'h0000_0001, 1'b0, 0, 0);
      add_byte(8'h00, 32'h0000_0001, 1'b0, 0, 0);
      add_byte(8'h00, 32'h0000_0001, 1'b0, 0, 0);
      add_byte(8'h80, 32'h0000_0001, 1'b1, 0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 11;
      rsp_idle_pct = 74;
      foreach (plan[i]) begin
         if (plan[i].is_cfg) load_config(plan[i].mode, plan[i].time_code, plan[i].sub_code);
         else send_byte(plan[i].item, plan[i].known, plan[i].known_bad);
      end

      random_phase(MODE_UNPACK, 8'h00, 8'hFF, 20);
      random_phase(MODE_PACK, 8'hFF, 8'h00, 20);
      req_idle_pct = 74;
      rsp_idle_pct = 11;
      random_phase(MODE_UNPACK, 8'h5A, 8'h5A, 20);
      random_phase(MODE_PACK, 8'hA5, 8'h3C, 20);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      random_phase(MODE_PACK, 8'h80, 8'h7F, 20);
      random_phase(MODE_UNPACK, 8'h01, 8'hFE, 15);

      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run: %0d bytes in, %0d bytes out, %0d time values rewritten, %0d malformed",
               bytes_sent, bytes_out, rewrites, malformed_bytes);
      $display("run: both modes, equal codes, sub-lists, short, long and cut time values");
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/tsr_pkg.sv
sv/tlv_timestamp_rewriter.sv
tb/testbench.sv
